FILE: rtl/core/itp_pkg.sv
// ============================================================================
// itp_pkg
// Shared widths, operator codes and character helpers for the infix to
// postfix converter.
// ============================================================================
package itp_pkg;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 3;
    localparam int RANK_W = 2;

    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [RANK_W-1:0] rank_t;

    // Stack entry codes
    localparam code_t CODE_PLUS  = 3'd0;
    localparam code_t CODE_MINUS = 3'd1;
    localparam code_t CODE_MUL   = 3'd2;
    localparam code_t CODE_DIV   = 3'd3;
    localparam code_t CODE_POW   = 3'd4;
    localparam code_t CODE_PAREN = 3'd5;

    // ASCII characters of interest
    localparam sym_t CH_PLUS   = 8'h2B;
    localparam sym_t CH_MINUS  = 8'h2D;
    localparam sym_t CH_MUL    = 8'h2A;
    localparam sym_t CH_DIV    = 8'h2F;
    localparam sym_t CH_POW    = 8'h5E;
    localparam sym_t CH_LPAREN = 8'h28;
    localparam sym_t CH_RPAREN = 8'h29;
    localparam sym_t CH_LOW_A  = 8'h61;
    localparam sym_t CH_LOW_Z  = 8'h7A;
    localparam sym_t CH_UP_A   = 8'h41;
    localparam sym_t CH_UP_Z   = 8'h5A;

    // Map a stack code back to its character
    function automatic sym_t code_char(input code_t code);
        sym_t ch;
        case (code)
            CODE_PLUS:  ch = CH_PLUS;
            CODE_MINUS: ch = CH_MINUS;
            CODE_MUL:   ch = CH_MUL;
            CODE_DIV:   ch = CH_DIV;
            CODE_POW:   ch = CH_POW;
            CODE_PAREN: ch = CH_LPAREN;
            default:    ch = '0;
        endcase
        return ch;
    endfunction

    // Precedence; an open paren ranks below all operators
    function automatic rank_t code_rank(input code_t code);
        rank_t r;
        case (code)
            CODE_PLUS, CODE_MINUS: r = 2'd1;
            CODE_MUL, CODE_DIV:    r = 2'd2;
            CODE_POW:              r = 2'd3;
            default:               r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_letter(input sym_t ch);
        return (ch inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]});
    endfunction

    function automatic logic is_operator(input sym_t ch);
        return (ch inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW});
    endfunction

    function automatic code_t op_code(input sym_t ch);
        code_t c;
        case (ch)
            CH_PLUS:  c = CODE_PLUS;
            CH_MINUS: c = CODE_MINUS;
            CH_MUL:   c = CODE_MUL;
            CH_DIV:   c = CODE_DIV;
            CH_POW:   c = CODE_POW;
            default:  c = CODE_PLUS;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/itp_if.sv
// ============================================================================
// itp_if
// Valid/ready channels of the infix to postfix converter: the character
// input channel and the postfix result channel.
// ============================================================================
interface itp_in_if
    import itp_pkg::*;
();
    logic valid;
    logic ready;
    sym_t symbol;
    logic end_of_expr;

    modport source (output valid, output symbol, output end_of_expr, input ready);
    modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

interface itp_out_if
    import itp_pkg::*;
();
    logic valid;
    logic ready;
    sym_t out_symbol;
    logic is_terminator;
    logic overflow;
    logic last;

    modport source (output valid, output out_symbol, output is_terminator,
                    output overflow, output last, input ready);
    modport sink   (input valid, input out_symbol, input is_terminator,
                    input overflow, input last, output ready);
endinterface

FILE: rtl/core/infix_to_postfix_converter.sv
// ============================================================================
// infix_to_postfix_converter
// Shunting-yard converter: one infix character in, postfix characters out.
// The operator stack lives in a synchronous RAM; the two top entries are
// cached in registers so that pop decisions and the last flag are known
// in the cycle of each pop.
// ============================================================================
//  channel | dir | transfer when        | payload
//  --------+-----+----------------------+-----------------------------------
//  in_ch   | in  | valid && ready       | symbol, end_of_expr
//  out_ch  | out | valid && ready       | out_symbol, is_terminator,
//          |     |                      | overflow, last
//
//  Letters, '(' and ignored characters are handled as they are accepted. An
//  operator, ')' or end item is accepted, then pops one entry at a time, each
//  pop with three or more entries stacked followed by a RAM read that refills
//  the cached second entry, then ends with the push, the discard of the
//  matching '(' (refilled the same way), the return on an empty stack or
//  the terminator. The single RAM read port calls for the separate refill step.
//  Reset clears the stack count and overflow flag; no clearing pass.
//  A stalled output holds every step that emits a result; input is taken only when idle
//  and the output register is free or draining.
// ============================================================================
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    itp_in_if.sink    in_ch,
    itp_out_if.source out_ch
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    localparam logic [1:0] MODE_OP    = 2'd0;
    localparam logic [1:0] MODE_RPAR  = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;
    localparam logic [1:0] MODE_DONE  = 2'd3;

    // Stack RAM
    code_t stack_mem [STACK_DEPTH];
    code_t rd_data_reg;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_seen_reg, ovf_seen_next;
    code_t         top_reg, top_next;
    code_t         sec_reg, sec_next;
    code_t         code_reg, code_next;

    logic          out_valid_reg, out_valid_next;
    sym_t          out_sym_reg, out_sym_next;
    logic          out_term_reg, out_term_next;
    logic          out_ovf_reg, out_ovf_next;
    logic          out_last_reg, out_last_next;

    logic          can_emit;
    logic          out_load;
    sym_t          o_sym;
    logic          o_term;
    logic          o_ovf;
    logic          o_last;
    logic          push_req;
    code_t         push_code;
    logic          pop_req;
    logic          mem_we;
    logic          rd_en;
    logic [CW-1:0] cnt_m3;
    logic          has_two;
    logic          top_pops;
    logic          sec_pops;

    assign can_emit = !out_valid_reg || out_ch.ready;
    assign cnt_m3   = count_reg - CW'(3);
    assign has_two  = (count_reg > CW'(1));
    assign top_pops = (count_reg != '0) && (top_reg != CODE_PAREN)
                      && (code_rank(code_reg) <= code_rank(top_reg));
    assign sec_pops = has_two && (sec_reg != CODE_PAREN)
                      && (code_rank(code_reg) <= code_rank(sec_reg));

    assign in_ch.ready          = (state_reg == ST_IDLE) && can_emit;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_symbol    = out_sym_reg;
    assign out_ch.is_terminator = out_term_reg;
    assign out_ch.overflow      = out_ovf_reg;
    assign out_ch.last          = out_last_reg;

    // Sequencer: classify, pop, push, emit
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        ovf_seen_next  = ovf_seen_reg;
        top_next       = top_reg;
        sec_next       = sec_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg;
        out_sym_next   = out_sym_reg;
        out_term_next  = out_term_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;
        o_sym          = '0;
        o_term         = 1'b0;
        o_ovf          = 1'b0;
        o_last         = 1'b0;
        push_req       = 1'b0;
        push_code      = CODE_PAREN;
        pop_req        = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;

        // Drain the output register on a transfer
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && can_emit)
                begin
                    if (in_ch.end_of_expr)
                    begin
                        mode_next  = MODE_FLUSH;
                        state_next = ST_POP;
                    end
                    else if (is_letter(in_ch.symbol))
                    begin
                        out_load = 1'b1;
                        o_sym    = in_ch.symbol;
                        o_last   = 1'b1;
                    end
                    else if (is_operator(in_ch.symbol))
                    begin
                        code_next  = op_code(in_ch.symbol);
                        mode_next  = MODE_OP;
                        state_next = ST_POP;
                    end
                    else if (in_ch.symbol == CH_LPAREN)
                    begin
                        push_req  = 1'b1;
                        push_code = CODE_PAREN;
                    end
                    else if (in_ch.symbol == CH_RPAREN)
                    begin
                        mode_next  = MODE_RPAR;
                        state_next = ST_POP;
                    end
                end
            end

            ST_POP:
            begin
                case (mode_reg)
                    MODE_OP:
                    begin
                        if (top_pops)
                        begin
                            if (can_emit)
                            begin
                                pop_req  = 1'b1;
                                out_load = 1'b1;
                                o_sym    = code_char(top_reg);
                                o_last   = !sec_pops;
                            end
                        end
                        else
                        begin
                            push_req   = 1'b1;
                            push_code  = code_reg;
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_RPAR:
                    begin
                        if (count_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (top_reg != CODE_PAREN)
                        begin
                            if (can_emit)
                            begin
                                pop_req  = 1'b1;
                                out_load = 1'b1;
                                o_sym    = code_char(top_reg);
                                o_last   = !(has_two && (sec_reg != CODE_PAREN));
                            end
                        end
                        else
                        begin
                            // Discard the matching open paren
                            pop_req   = 1'b1;
                            mode_next = MODE_DONE;
                        end
                    end
                    MODE_FLUSH:
                    begin
                        if (can_emit)
                        begin
                            out_load = 1'b1;
                            if (count_reg != '0)
                            begin
                                pop_req = 1'b1;
                                o_sym   = code_char(top_reg);
                            end
                            else
                            begin
                                o_term        = 1'b1;
                                o_ovf         = ovf_seen_reg;
                                o_last        = 1'b1;
                                ovf_seen_next = 1'b0;
                                state_next    = ST_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_LOAD:
            begin
                // Refill the cached second entry from the RAM
                sec_next   = rd_data_reg;
                state_next = ST_POP;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Pop the top; fetch the new second entry when one exists
        if (pop_req)
        begin
            count_next = count_reg - CW'(1);
            top_next   = sec_reg;
            if (count_reg >= CW'(3))
            begin
                rd_en      = 1'b1;
                state_next = ST_LOAD;
            end
        end

        // Push, or drop and flag on a full stack
        if (push_req)
        begin
            if (count_reg == CW'(STACK_DEPTH))
            begin
                ovf_seen_next = 1'b1;
            end
            else
            begin
                mem_we     = 1'b1;
                top_next   = push_code;
                sec_next   = top_reg;
                count_next = count_reg + CW'(1);
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = o_sym;
            out_term_next  = o_term;
            out_ovf_next   = o_ovf;
            out_last_next  = o_last;
        end
    end

    // Stack RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[count_reg[AW-1:0]] <= push_code;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[cnt_m3[AW-1:0]];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_OP;
            count_reg     <= '0;
            ovf_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            ovf_seen_reg  <= ovf_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and cached stack entries
    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        sec_reg      <= sec_next;
        code_reg     <= code_next;
        out_sym_reg  <= out_sym_next;
        out_term_reg <= out_term_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: rtl/core/itp_checker.sv
// ============================================================================
// itp_checker
// Port-level checks of the infix to postfix converter, bound to the top.
// ============================================================================
module itp_checker
    import itp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input sym_t out_symbol,
    input logic is_terminator,
    input logic overflow,
    input logic last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(last))
        else $error("stalled result changed");

    // Terminator carries zero symbol and closes the item
    a_term_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_terminator |-> (out_symbol == '0) && last)
        else $error("malformed terminator");

    // Overflow is reported only on the terminator
    a_ovf_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> is_terminator)
        else $error("overflow outside terminator");

    // No new input while an item still has results to deliver
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken mid-item");

    // Input is taken only when the result slot can be free
    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("input taken with a blocked result");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_symbol    (out_ch.out_symbol),
    .is_terminator (out_ch.is_terminator),
    .overflow      (out_ch.overflow),
    .last          (out_ch.last)
);
